>>> rtl/hdm_pkg.sv
// ----------------------------------------------------------------------------
// hdm_pkg
// shared constants and helpers for the holonomic drive mixer
// ----------------------------------------------------------------------------
package hdm_pkg;

    localparam int SAMPLE_WIDTH_DEF     = 16;
    localparam int ANGLE_ITERATIONS_DEF = 16;

    localparam int DEADBAND_WIDTH = 15;
    localparam logic [DEADBAND_WIDTH-1:0] DEADBAND_RESET = 15'd3277;

    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;
    localparam logic REG_DEADBAND = 1'b0;

    // gain constants, fraction of 30 bits
    localparam int K_FRAC = 30;
    localparam logic [63:0] INVK_Q30     = 64'd652032874;
    localparam logic [63:0] INVSQRT2_Q30 = 64'd759250125;
    localparam logic [63:0] START_Q30    =
        (INVK_Q30 * INVSQRT2_Q30 + (64'd1 << (K_FRAC - 1))) >> K_FRAC;

    function automatic int guard_bits(input int sw);
        return (sw <= 24) ? 8 : 0;
    endfunction

endpackage

>>> rtl/hdm_sqrt.sv
// ----------------------------------------------------------------------------
// hdm_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module hdm_sqrt
    import hdm_pkg::*;
#(
    parameter int RW  = 24,
    parameter int SBW = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2*RW-1:0]   in_rad,
    input  logic [SBW-1:0]    in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [RW-1:0]     out_root,
    output logic [SBW-1:0]    out_side
);

    logic [RW-1:0]   vld_reg;
    logic [RW-1:0]   en;
    logic [2*RW-1:0] rad_reg  [RW];
    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [SBW-1:0]  side_reg [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            logic            vld_in;
            logic [2*RW-1:0] rad_in;
            logic [RW+1:0]   rem_in;
            logic [RW-1:0]   root_in;
            logic [SBW-1:0]  side_in;
            logic [RW+1:0]   remt;
            logic [RW+1:0]   trial;
            logic [RW+1:0]   rem_next;
            logic [RW-1:0]   root_next;

            if (k == 0) begin : g_first
                assign vld_in  = in_valid;
                assign rad_in  = in_rad;
                assign rem_in  = '0;
                assign root_in = '0;
                assign side_in = in_side;
            end
            else begin : g_rest
                assign vld_in  = vld_reg[k-1];
                assign rad_in  = rad_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            if (k == RW - 1) begin : g_last_en
                assign en[k] = !vld_reg[k] || out_ready;
            end
            else begin : g_mid_en
                assign en[k] = !vld_reg[k] || en[k+1];
            end

            always_comb
            begin
                remt  = {rem_in[RW-1:0], rad_in[2*RW-1-2*k -: 2]};
                trial = {root_in, 2'b01};
                if (remt >= trial)
                begin
                    rem_next  = remt - trial;
                    root_next = {root_in[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = remt;
                    root_next = {root_in[RW-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (en[k])
                    vld_reg[k] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (en[k] && vld_in)
                begin
                    rad_reg[k]  <= rad_in;
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign in_ready  = en[0];
    assign out_valid = vld_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

>>> rtl/hdm_cordic.sv
// ----------------------------------------------------------------------------
// hdm_cordic
// pipelined cordic, vectoring on (xd, yd) steers rotation of (u, v); in_hold passes them through
// ----------------------------------------------------------------------------
module hdm_cordic
    import hdm_pkg::*;
#(
    parameter int CW   = 27,
    parameter int ITER = 16,
    parameter int SBW  = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] in_xd,
    input  logic signed [CW-1:0] in_yd,
    input  logic signed [CW-1:0] in_u,
    input  logic signed [CW-1:0] in_v,
    input  logic                 in_hold,
    input  logic [SBW-1:0]       in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CW-1:0] out_u,
    output logic signed [CW-1:0] out_v,
    output logic [SBW-1:0]       out_side
);

    logic [ITER-1:0]      vld_reg;
    logic [ITER-1:0]      en;
    logic signed [CW-1:0] xd_reg   [ITER];
    logic signed [CW-1:0] yd_reg   [ITER];
    logic signed [CW-1:0] u_reg    [ITER];
    logic signed [CW-1:0] v_reg    [ITER];
    logic [ITER-1:0]      hold_reg;
    logic [SBW-1:0]       side_reg [ITER];

    genvar i;
    generate
        for (i = 0; i < ITER; i++) begin : g_stage
            logic                 vld_in;
            logic signed [CW-1:0] xd_in;
            logic signed [CW-1:0] yd_in;
            logic signed [CW-1:0] u_in;
            logic signed [CW-1:0] v_in;
            logic                 hold_in;
            logic [SBW-1:0]       side_in;
            logic signed [CW-1:0] xd_next;
            logic signed [CW-1:0] yd_next;
            logic signed [CW-1:0] u_next;
            logic signed [CW-1:0] v_next;

            if (i == 0) begin : g_first
                assign vld_in  = in_valid;
                assign xd_in   = in_xd;
                assign yd_in   = in_yd;
                assign u_in    = in_u;
                assign v_in    = in_v;
                assign hold_in = in_hold;
                assign side_in = in_side;
            end
            else begin : g_rest
                assign vld_in  = vld_reg[i-1];
                assign xd_in   = xd_reg[i-1];
                assign yd_in   = yd_reg[i-1];
                assign u_in    = u_reg[i-1];
                assign v_in    = v_reg[i-1];
                assign hold_in = hold_reg[i-1];
                assign side_in = side_reg[i-1];
            end

            if (i == ITER - 1) begin : g_last_en
                assign en[i] = !vld_reg[i] || out_ready;
            end
            else begin : g_mid_en
                assign en[i] = !vld_reg[i] || en[i+1];
            end

            always_comb
            begin
                if (hold_in)
                begin
                    xd_next = xd_in;
                    yd_next = yd_in;
                    u_next  = u_in;
                    v_next  = v_in;
                end
                else if (!yd_in[CW-1])
                begin
                    xd_next = xd_in + (yd_in >>> i);
                    yd_next = yd_in - (xd_in >>> i);
                    u_next  = u_in - (v_in >>> i);
                    v_next  = v_in + (u_in >>> i);
                end
                else
                begin
                    xd_next = xd_in - (yd_in >>> i);
                    yd_next = yd_in + (xd_in >>> i);
                    u_next  = u_in + (v_in >>> i);
                    v_next  = v_in - (u_in >>> i);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i] <= 1'b0;
                else if (en[i])
                    vld_reg[i] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (en[i] && vld_in)
                begin
                    xd_reg[i]   <= xd_next;
                    yd_reg[i]   <= yd_next;
                    u_reg[i]    <= u_next;
                    v_reg[i]    <= v_next;
                    hold_reg[i] <= hold_in;
                    side_reg[i] <= side_in;
                end
            end
        end
    endgenerate

    assign in_ready  = en[0];
    assign out_valid = vld_reg[ITER-1];
    assign out_u     = u_reg[ITER-1];
    assign out_v     = v_reg[ITER-1];
    assign out_side  = side_reg[ITER-1];

endmodule

>>> rtl/holonomic_drive_mixer_unit.sv
// ----------------------------------------------------------------------------
// holonomic_drive_mixer_unit
// joystick sample to four x-drive wheel commands, fixed point
//
// channel   handshake              payload
// in        in_valid / in_ready    stick_x, stick_forward, stick_rotate
// out       out_valid / out_ready  wheel_front_left/right, wheel_rear_left/right
// config    apb write/read         deadband at byte address 0
//
// one item per cycle while out_ready holds; the pipeline runs stage a, the
// bit-per-stage square root, stage b, the cordic stage chain and stage c
// rst_n clears all stage valid bits and loads deadband with its default
// a stalled output holds its item; upstream stages keep filling empty slots
// ----------------------------------------------------------------------------
module holonomic_drive_mixer_unit
    import hdm_pkg::*;
#(
    parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF,
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [APB_ADDR_WIDTH-1:0]        paddr,
    input  logic [APB_DATA_WIDTH-1:0]        pwdata,
    output logic [APB_DATA_WIDTH-1:0]        prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]   stick_x,
    input  logic signed [SAMPLE_WIDTH-1:0]   stick_forward,
    input  logic signed [SAMPLE_WIDTH-1:0]   stick_rotate,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]   wheel_front_left,
    output logic signed [SAMPLE_WIDTH-1:0]   wheel_front_right,
    output logic signed [SAMPLE_WIDTH-1:0]   wheel_rear_left,
    output logic signed [SAMPLE_WIDTH-1:0]   wheel_rear_right
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int GUARD = guard_bits(SAMPLE_WIDTH);
    localparam int RW    = SW + GUARD;
    localparam int CW    = RW + 3;
    localparam int MW    = ((SW > DEADBAND_WIDTH) ? SW : DEADBAND_WIDTH) + 1;
    localparam int SQ_SBW = 3 * CW + 1;
    localparam int CO_SBW = CW + 1;

    localparam logic signed [CW-1:0] RND = CW'((64'd1 << GUARD) >> 1);
    localparam logic signed [CW-1:0] SAT_HI = {{(CW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [CW-1:0] SAT_LO = {{(CW-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic [K_FRAC-1:0] K_START = START_Q30[K_FRAC-1:0];
    localparam logic [K_FRAC-1:0] K_PLAIN = INVSQRT2_Q30[K_FRAC-1:0];
    localparam logic [RW+K_FRAC-1:0] K_HALF = (RW+K_FRAC)'(64'd1 << (K_FRAC - 1));

    // configuration
    logic [DEADBAND_WIDTH-1:0] deadband_reg;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DEADBAND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deadband_reg <= DEADBAND_RESET;
        else if (cfg_wr)
            deadband_reg <= pwdata[DEADBAND_WIDTH-1:0];
    end

    always_comb
    begin
        if (paddr[2] == REG_DEADBAND)
            prdata = APB_DATA_WIDTH'(deadband_reg);
        else
            prdata = '0;
    end

    function automatic logic signed [CW-1:0] dead_scale(
        input logic signed [SW:0]          v,
        input logic [DEADBAND_WIDTH-1:0]   db
    );
        logic [SW:0] mag;
        logic signed [CW-1:0] ext;
        mag = v[SW] ? SW'(0) - v : v;
        ext = CW'(v);
        if (MW'(mag) < MW'(db))
            return '0;
        return ext <<< GUARD;
    endfunction

    function automatic logic signed [SW-1:0] finish(input logic signed [CW-1:0] s);
        logic signed [CW-1:0] q;
        q = (s + RND) >>> GUARD;
        if (q > SAT_HI)
            q = SAT_HI;
        else if (q < SAT_LO)
            q = SAT_LO;
        return q[SW-1:0];
    endfunction

    // stage a: squares and deadband
    logic                  a_vld_reg;
    logic [2*SW-1:0]       a_sum_reg;
    logic signed [CW-1:0]  a_xd_reg;
    logic signed [CW-1:0]  a_yd_reg;
    logic signed [CW-1:0]  a_rot_reg;
    logic                  a_zero_reg;
    logic                  a_en;
    logic                  sq_in_ready;

    logic signed [SW:0]     x_ext;
    logic signed [SW:0]     y_ext;
    logic signed [SW:0]     r_ext;
    logic signed [2*SW+1:0] x_sq;
    logic signed [2*SW+1:0] y_sq;
    logic [2*SW-1:0]        sum_next;
    logic signed [CW-1:0]   xd_next;
    logic signed [CW-1:0]   yd_next;
    logic signed [CW-1:0]   rot_next;

    always_comb
    begin
        x_ext    = {stick_x[SW-1], stick_x};
        y_ext    = -{stick_forward[SW-1], stick_forward};
        r_ext    = {stick_rotate[SW-1], stick_rotate};
        x_sq     = x_ext * x_ext;
        y_sq     = y_ext * y_ext;
        sum_next = x_sq[2*SW-1:0] + y_sq[2*SW-1:0];
        xd_next  = dead_scale(x_ext, deadband_reg);
        yd_next  = dead_scale(y_ext, deadband_reg);
        rot_next = dead_scale(r_ext, deadband_reg);
    end

    assign a_en     = !a_vld_reg || sq_in_ready;
    assign in_ready = a_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (a_en)
            a_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (a_en && in_valid)
        begin
            a_sum_reg  <= sum_next;
            a_xd_reg   <= xd_next;
            a_yd_reg   <= yd_next;
            a_rot_reg  <= rot_next;
            a_zero_reg <= (xd_next == '0) && (yd_next == '0);
        end
    end

    // square root of (x*x + y*y) scaled by the guard bits
    logic              sq_out_valid;
    logic              sq_out_ready;
    logic [RW-1:0]     sq_root;
    logic [SQ_SBW-1:0] sq_side;

    hdm_sqrt #(
        .RW  (RW),
        .SBW (SQ_SBW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_vld_reg),
        .in_ready  (sq_in_ready),
        .in_rad    ((2*RW)'(a_sum_reg) << (2 * GUARD)),
        .in_side   ({a_xd_reg, a_yd_reg, a_rot_reg, a_zero_reg}),
        .out_valid (sq_out_valid),
        .out_ready (sq_out_ready),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // stage b: start vector scaling and half-turn fold
    logic                  b_vld_reg;
    logic signed [CW-1:0]  b_xd_reg;
    logic signed [CW-1:0]  b_yd_reg;
    logic signed [CW-1:0]  b_uv_reg;
    logic                  b_hold_reg;
    logic [CO_SBW-1:0]     b_side_reg;
    logic                  b_en;
    logic                  co_in_ready;

    logic signed [CW-1:0]   sb_xd;
    logic signed [CW-1:0]   sb_yd;
    logic signed [CW-1:0]   sb_rot;
    logic                   sb_zero;
    logic [RW+K_FRAC-1:0]   prod;
    logic signed [CW-1:0]   uv_next;

    always_comb
    begin
        {sb_xd, sb_yd, sb_rot, sb_zero} = sq_side;
        prod    = (RW+K_FRAC)'(sq_root) * (RW+K_FRAC)'(sb_zero ? K_PLAIN : K_START);
        prod    = prod + K_HALF;
        uv_next = CW'({3'b000, prod[K_FRAC +: RW]});
    end

    assign b_en         = !b_vld_reg || co_in_ready;
    assign sq_out_ready = b_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (b_en)
            b_vld_reg <= sq_out_valid;
    end

    always_ff @(posedge clk)
    begin
        if (b_en && sq_out_valid)
        begin
            b_xd_reg   <= sb_xd[CW-1] ? -sb_xd : sb_xd;
            b_yd_reg   <= sb_xd[CW-1] ? -sb_yd : sb_yd;
            b_uv_reg   <= uv_next;
            b_hold_reg <= sb_zero;
            b_side_reg <= {sb_rot, sb_xd[CW-1]};
        end
    end

    // cordic pass
    logic                 co_out_valid;
    logic                 co_out_ready;
    logic signed [CW-1:0] co_u;
    logic signed [CW-1:0] co_v;
    logic [CO_SBW-1:0]    co_side;

    hdm_cordic #(
        .CW   (CW),
        .ITER (ANGLE_ITERATIONS),
        .SBW  (CO_SBW)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_vld_reg),
        .in_ready  (co_in_ready),
        .in_xd     (b_xd_reg),
        .in_yd     (b_yd_reg),
        .in_u      (b_uv_reg),
        .in_v      (b_uv_reg),
        .in_hold   (b_hold_reg),
        .in_side   (b_side_reg),
        .out_valid (co_out_valid),
        .out_ready (co_out_ready),
        .out_u     (co_u),
        .out_v     (co_v),
        .out_side  (co_side)
    );

    // stage c: wheel mixing, rounding and saturation
    logic                  c_vld_reg;
    logic signed [SW-1:0]  fl_reg;
    logic signed [SW-1:0]  fr_reg;
    logic signed [SW-1:0]  rl_reg;
    logic signed [SW-1:0]  rr_reg;
    logic                  c_en;

    logic signed [CW-1:0]  c_rot;
    logic                  c_flip;
    logic signed [CW-1:0]  c_u;
    logic signed [CW-1:0]  c_v;

    always_comb
    begin
        {c_rot, c_flip} = co_side;
        c_u = c_flip ? -co_u : co_u;
        c_v = c_flip ? -co_v : co_v;
    end

    assign c_en         = !c_vld_reg || out_ready;
    assign co_out_ready = c_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (c_en)
            c_vld_reg <= co_out_valid;
    end

    always_ff @(posedge clk)
    begin
        if (c_en && co_out_valid)
        begin
            fl_reg <= finish(c_v + c_rot);
            fr_reg <= finish(c_u + c_rot);
            rl_reg <= finish(c_rot - c_u);
            rr_reg <= finish(c_rot - c_v);
        end
    end

    assign out_valid         = c_vld_reg;
    assign wheel_front_left  = fl_reg;
    assign wheel_front_right = fr_reg;
    assign wheel_rear_left   = rl_reg;
    assign wheel_rear_right  = rr_reg;

`ifndef SYNTHESIS
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> deadband_reg == $past(pwdata[DEADBAND_WIDTH-1:0]))
        else $error("deadband write lost");

    a_prdata_upper: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[APB_DATA_WIDTH-1:DEADBAND_WIDTH] == '0)
        else $error("read data upper bits set");

    a_zero_hold: assert property (@(posedge clk) disable iff (!rst_n)
        b_vld_reg && b_hold_reg |-> b_xd_reg == '0 && b_yd_reg == '0)
        else $error("cordic bypass with nonzero direction");
`endif

endmodule
